// File: sv/sm3_pkg.sv
// Shared types and constants of the SM3 hash engine.
package sm3_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [COUNT_W-1:0] t_byte_count;

    localparam t_word SM3_IV [0:7] = '{
        32'h7380_166F, 32'h4914_B2B9, 32'h1724_42D7, 32'hDA8A_0600,
        32'hA96F_30BC, 32'h1631_38AA, 32'hE38D_EE4D, 32'hB0FB_0E4E
    };

    localparam t_word T_EARLY     = 32'h79CC_4519;
    localparam t_word T_LATE_ROT  = 32'h9D8A_7A87;
    localparam t_word PAD_MARK    = 32'h8000_0000;

endpackage

// File: sv/sm3_in_if.sv
// Message word channel of the SM3 hash engine.
interface sm3_in_if import sm3_pkg::*; ();
    logic        valid;
    logic        ready;
    t_word       msg_word;
    t_byte_count byte_count;
    logic        last_word;

    modport source (output valid, msg_word, byte_count, last_word, input ready);
    modport sink   (input valid, msg_word, byte_count, last_word, output ready);
endinterface

// File: sv/sm3_out_if.sv
// Digest word channel of the SM3 hash engine.
interface sm3_out_if import sm3_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word digest_word;
    logic  digest_last;

    modport source (output valid, digest_word, digest_last, input ready);
    modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

// File: sv/sm3_hash_engine_top.sv
// SM3 hash engine: message word intake, padding, round unit and digest output.
// A message word without the last mark is accepted while the engine is idle; the word that
// completes a 16-word block leaves the engine busy, taking no new word, while its single round
// unit performs one compression round per cycle.
// The last word starts the padding sequencer, which appends one padding word per cycle,
// pausing while a compression runs, and runs one or two further compressions, after which
// the eight digest words are offered one per cycle, each held until it is taken, and the
// engine returns to its initial value. No new word is accepted from the last word until the
// final digest word has been taken.
module sm3_hash_engine_top import sm3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sm3_in_if.sink    i_msg,
    sm3_out_if.source o_digest
);

    localparam logic [3:0] FILL_LEN_HI = 4'd14;
    localparam logic [3:0] FILL_FULL   = 4'd15;
    localparam logic [5:0] ROUND_LAST  = 6'd63;
    localparam logic [5:0] ROUND_SWAP  = 6'd15;
    localparam logic [2:0] OUT_LAST    = 3'd7;

    typedef enum logic [2:0] {S_IDLE, S_MARK, S_ZERO, S_COMP, S_OUT} t_state;

    t_state      r_state, r_ret, n_cont;
    logic [3:0]  r_fill;
    logic [63:0] r_bitlen;
    t_word       r_chain [0:7];
    t_word       r_v     [0:7];
    t_word       n_v     [0:7];
    t_word       r_w     [0:15];
    t_word       r_t;
    logic [5:0]  r_round;
    logic [2:0]  r_out_idx;
    logic        r_len_hi;

    logic        in_acc, out_acc, push_en, len_set;
    t_word       push_val, w_new, keep, mark;
    t_word       a12, ss1, ss2, ff, gg, tt1, tt2;
    logic [2:0]  c_sat;
    logic [63:0] len_add;

    function automatic t_word rotl(input t_word x, input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    assign in_acc  = i_msg.valid && i_msg.ready;
    assign out_acc = o_digest.valid && o_digest.ready;

    assign i_msg.ready          = (r_state == S_IDLE);
    assign o_digest.valid       = (r_state == S_OUT);
    assign o_digest.digest_word = r_chain[r_out_idx];
    assign o_digest.digest_last = (r_out_idx == OUT_LAST);

    always_comb begin
        c_sat = i_msg.byte_count[2] ? 3'd4 : i_msg.byte_count;
        case (c_sat)
            3'd1:    begin keep = 32'hFF00_0000; mark = PAD_MARK >> 8;  end
            3'd2:    begin keep = 32'hFFFF_0000; mark = PAD_MARK >> 16; end
            3'd3:    begin keep = 32'hFFFF_FF00; mark = PAD_MARK >> 24; end
            default: begin keep = '0;            mark = PAD_MARK;       end
        endcase
        len_add = i_msg.last_word ? {58'd0, c_sat, 3'd0} : 64'd32;

        push_en  = 1'b0;
        push_val = '0;
        n_cont   = r_state;
        len_set  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    push_en = 1'b1;
                    if (!i_msg.last_word) begin
                        push_val = i_msg.msg_word;
                        n_cont   = S_IDLE;
                    end else if (c_sat[2]) begin
                        push_val = i_msg.msg_word;
                        n_cont   = S_MARK;
                    end else begin
                        push_val = (i_msg.msg_word & keep) | mark;
                        n_cont   = S_ZERO;
                    end
                end
            end
            S_MARK: begin
                push_en  = 1'b1;
                push_val = PAD_MARK;
                n_cont   = S_ZERO;
            end
            S_ZERO: begin
                push_en = 1'b1;
                if (r_len_hi) begin
                    push_val = r_bitlen[31:0];
                    n_cont   = S_OUT;
                end else if (r_fill == FILL_LEN_HI) begin
                    push_val = r_bitlen[63:32];
                    len_set  = 1'b1;
                    n_cont   = S_ZERO;
                end else begin
                    push_val = '0;
                    n_cont   = S_ZERO;
                end
            end
            default: ;
        endcase

        w_new = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 15)) ^ rotl(r_w[3], 7) ^ r_w[10];

        a12 = rotl(r_v[0], 12);
        ss1 = rotl(a12 + r_v[4] + r_t, 7);
        ss2 = ss1 ^ a12;
        if (r_round[5:4] == 2'd0) begin
            ff = r_v[0] ^ r_v[1] ^ r_v[2];
            gg = r_v[4] ^ r_v[5] ^ r_v[6];
        end else begin
            ff = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            gg = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end
        tt1 = ff + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_v[7] + ss1 + r_w[0];
        n_v[0] = tt1;
        n_v[1] = r_v[0];
        n_v[2] = rotl(r_v[1], 9);
        n_v[3] = r_v[2];
        n_v[4] = perm0(tt2);
        n_v[5] = r_v[4];
        n_v[6] = rotl(r_v[5], 19);
        n_v[7] = r_v[6];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_fill    <= '0;
            r_bitlen  <= '0;
            r_chain   <= SM3_IV;
            r_round   <= '0;
            r_out_idx <= '0;
            r_len_hi  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_bitlen <= r_bitlen + len_add;
            end
            if (len_set) begin
                r_len_hi <= 1'b1;
            end
            if (push_en) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= push_val;
                if (r_fill == FILL_FULL) begin
                    r_fill  <= '0;
                    r_state <= S_COMP;
                    r_ret   <= n_cont;
                    r_v     <= r_chain;
                    r_round <= '0;
                    r_t     <= T_EARLY;
                end else begin
                    r_fill  <= r_fill + 4'd1;
                    r_state <= n_cont;
                end
            end
            case (r_state)
                S_COMP: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_new;
                    r_v     <= n_v;
                    r_round <= r_round + 6'd1;
                    r_t     <= (r_round == ROUND_SWAP) ? T_LATE_ROT : rotl(r_t, 1);
                    if (r_round == ROUND_LAST) begin
                        for (int i = 0; i < 8; i++) begin
                            r_chain[i] <= r_chain[i] ^ n_v[i];
                        end
                        r_state <= r_ret;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == OUT_LAST) begin
                            r_chain  <= SM3_IV;
                            r_bitlen <= '0;
                            r_fill   <= '0;
                            r_len_hi <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // The engine never offers a digest word while it can take a message word.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_digest.valid && i_msg.ready))
        else $error("digest offered while taking message words");

    // The round counter rests at zero outside a compression.
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_COMP) |-> (r_round == '0))
        else $error("round counter not at rest");

    // A compression only ever runs on a complete block.
    a_comp_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_fill == '0))
        else $error("compression with a partly filled block");

    // After the final digest word the chaining value and length start afresh.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_digest.digest_last) |=>
            (r_chain[0] == SM3_IV[0] && r_chain[7] == SM3_IV[7] && r_bitlen == '0
             && r_state == S_IDLE))
        else $error("engine not restarted after digest");

endmodule
